// ===== design/bounded_ordered_list_engine_core_assert.svh =====
// ----------------------------------------------------------------------------
// bounded ordered list engine - assertion macros
// shared property forms, clocked on clk_i and disabled while rst_ni is low
// ----------------------------------------------------------------------------
`ifndef BOUNDED_ORDERED_LIST_ENGINE_CORE_ASSERT_SVH
`define BOUNDED_ORDERED_LIST_ENGINE_CORE_ASSERT_SVH

// same-cycle implication
`define BOLEC_ASSERT_IMPL(name, pre, post, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error(msg);

// next-cycle implication
`define BOLEC_ASSERT_NEXT(name, pre, post, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);

`endif

// ===== design/bolec_pkg.sv =====
// ----------------------------------------------------------------------------
// bolec_pkg
// command codes, field widths and the cell control struct of the list engine
// ----------------------------------------------------------------------------
`default_nettype none

package bolec_pkg;

  // fixed field widths of the item channels
  localparam int unsigned CMD_W = 4;
  localparam int unsigned VAL_W = 32;
  localparam int unsigned POS_W = 7;
  localparam int unsigned CNT_W = 7;
  localparam int unsigned CFG_W = 7;

  // command codes
  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH_FRONT = 4'd0,
    CMD_PUSH_BACK  = 4'd1,
    CMD_POP_FRONT  = 4'd2,
    CMD_POP_BACK   = 4'd3,
    CMD_READ_AT    = 4'd4,
    CMD_INSERT_AT  = 4'd5,
    CMD_REMOVE     = 4'd6,
    CMD_CONTAINS   = 4'd7,
    CMD_CLEAR      = 4'd8
  } bolec_cmd_e;

  // broadcast control to every cell of the row
  typedef struct packed {
    logic open;     // open a gap at the position: upper cells take the left neighbour
    logic close;    // close a gap at the position: cells take the right neighbour
    logic compare;  // register the per-cell match against the search word
  } cell_op_t;

endpackage

`default_nettype wire

// ===== design/bolec_in_if.sv =====
// ----------------------------------------------------------------------------
// bolec_in_if
// command item channel: valid/ready with command, data word and position
// ----------------------------------------------------------------------------
`default_nettype none

interface bolec_in_if;
  import bolec_pkg::*;

  logic             valid;
  logic             ready;
  logic [CMD_W-1:0] cmd;
  logic [VAL_W-1:0] value;
  logic [POS_W-1:0] position;

  modport source (output valid, output cmd, output value, output position, input ready);
  modport sink   (input valid, input cmd, input value, input position, output ready);
endinterface

`default_nettype wire

// ===== design/bolec_out_if.sv =====
// ----------------------------------------------------------------------------
// bolec_out_if
// result item channel: valid/ready with status, data and list end words
// ----------------------------------------------------------------------------
`default_nettype none

interface bolec_out_if;
  import bolec_pkg::*;

  logic             valid;
  logic             ready;
  logic             ok;
  logic [VAL_W-1:0] data_out;
  logic [CNT_W-1:0] entry_count;
  logic             is_full;
  logic             is_empty;
  logic [VAL_W-1:0] front_value;
  logic [VAL_W-1:0] back_value;

  modport source (output valid, output ok, output data_out, output entry_count,
                  output is_full, output is_empty, output front_value,
                  output back_value, input ready);
  modport sink   (input valid, input ok, input data_out, input entry_count,
                  input is_full, input is_empty, input front_value,
                  input back_value, output ready);
endinterface

`default_nettype wire

// ===== design/bolec_cell.sv =====
// ----------------------------------------------------------------------------
// bolec_cell
// one list slot: holds a data word, shifts with its neighbours, flags a match
// ----------------------------------------------------------------------------
`default_nettype none

module bolec_cell #(
  parameter int unsigned DW    = 32,
  parameter int unsigned AW    = 6,
  parameter int unsigned CW    = 7,
  parameter int unsigned INDEX = 0
) (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  wire bolec_pkg::cell_op_t op_i,
  input  wire  [AW-1:0]         at_i,
  input  wire  [CW-1:0]         count_i,
  input  wire  [DW-1:0]         value_i,
  input  wire  [DW-1:0]         left_i,
  input  wire  [DW-1:0]         right_i,
  output logic [DW-1:0]         data_o,
  output logic                  match_o
);
  import bolec_pkg::*;

  localparam logic [AW-1:0] IDX_A = AW'(INDEX);
  localparam logic [CW-1:0] IDX_C = CW'(INDEX);

  logic [DW-1:0] data_q, data_d;
  logic          match_q;

  // shift or load per the broadcast op
  always_comb begin
    data_d = data_q;
    if (op_i.open) begin
      if (IDX_A > at_i) begin
        data_d = left_i;
      end else if (IDX_A == at_i) begin
        data_d = value_i;
      end
    end else if (op_i.close && (IDX_A >= at_i)) begin
      data_d = right_i;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  // match only counts for slots inside the list
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      match_q <= 1'b0;
    end else if (op_i.compare) begin
      match_q <= (IDX_C < count_i) && (data_q == value_i);
    end
  end

  assign data_o  = data_q;
  assign match_o = match_q;

endmodule

`default_nettype wire

// ===== design/bounded_ordered_list_engine_core.sv =====
// ----------------------------------------------------------------------------
// bounded_ordered_list_engine_core
// an accepted item runs the compare, execute and report steps, then its result
//   is registered on rsp_o; no new item is taken until that sequence ends, and
//   a result still waiting on rsp_o holds the report step
// reset: count cleared, capacity limit set to 64, cell words left unwritten
// ----------------------------------------------------------------------------
`default_nettype none

`include "bounded_ordered_list_engine_core_assert.svh"

module bounded_ordered_list_engine_core #(
  parameter int unsigned DEPTH      = 64,
  parameter int unsigned DATA_WIDTH = 32
) (
  input  wire                              clk_i,
  input  wire                              rst_ni,
  input  wire                              cfg_we_i,
  input  wire  [bolec_pkg::CFG_W-1:0]      cfg_wdata_i,
  bolec_in_if.sink                         req_i,
  bolec_out_if.source                      rsp_o
);
  import bolec_pkg::*;

  localparam int unsigned DW = DATA_WIDTH;
  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned XW = (CW > POS_W) ? CW : POS_W;

  localparam logic [XW-1:0] DEPTH_X = XW'(DEPTH);

  // sequencer states
  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_MATCH = 2'd1;
  localparam logic [1:0] S_EXEC  = 2'd2;
  localparam logic [1:0] S_DONE  = 2'd3;

  // widen or trim a stored word to the result width
  function automatic logic [VAL_W-1:0] to_word(input logic [DW-1:0] d);
    logic [DW+VAL_W-1:0] w;
    w = {{VAL_W{1'b0}}, d};
    return w[VAL_W-1:0];
  endfunction

  logic [1:0]       state_q, state_d;
  logic [CFG_W-1:0] max_q;
  logic [CW-1:0]    cnt_q, cnt_d;
  bolec_cmd_e       cmd_q;
  logic [DW-1:0]    val_q;
  logic [POS_W-1:0] pos_q;
  logic             ok_q, ok_d;
  logic [DW-1:0]    dat_q, dat_d;

  logic             rsp_valid_q;
  logic             rsp_ok_q;
  logic [VAL_W-1:0] rsp_data_q;
  logic [CNT_W-1:0] rsp_cnt_q;
  logic             rsp_full_q;
  logic             rsp_empty_q;
  logic [VAL_W-1:0] rsp_front_q;
  logic [VAL_W-1:0] rsp_back_q;

  cell_op_t         op;
  logic [AW-1:0]    at;
  logic [DW-1:0]    cell_data [DEPTH];
  logic [DEPTH-1:0] match_vec;

  logic [DW+VAL_W-1:0] vin_w;
  logic [DW-1:0]       vin;
  logic                accept;
  logic                rsp_free;

  logic [XW-1:0]    cnt_x, pos_x, max_x, lim_x, last_x;
  logic             can_add, non_empty, pos_in;
  logic [DEPTH-1:0] first_hot;
  logic [AW-1:0]    first_idx;
  logic             found;

  assign vin_w    = {{DW{1'b0}}, req_i.value};
  assign vin      = vin_w[DW-1:0];
  assign accept   = req_i.valid && req_i.ready;
  assign rsp_free = !rsp_valid_q || rsp_o.ready;

  assign req_i.ready = (state_q == S_IDLE);

  // count, limit and position in one common width
  assign cnt_x     = XW'(cnt_q);
  assign pos_x     = XW'(pos_q);
  assign max_x     = XW'(max_q);
  assign lim_x     = (max_x > DEPTH_X) ? DEPTH_X : max_x;
  assign last_x    = cnt_x - XW'(1);
  assign can_add   = cnt_x < lim_x;
  assign non_empty = (cnt_q != '0);
  assign pos_in    = pos_x < cnt_x;

  // lowest matching slot
  assign first_hot = match_vec & (~match_vec + {{(DEPTH-1){1'b0}}, 1'b1});
  assign found     = |match_vec;

  always_comb begin
    first_idx = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (first_hot[i]) begin
        first_idx = first_idx | AW'(i);
      end
    end
  end

  // row of cells
  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic [DW-1:0] left_w, right_w;
    if (g == 0) begin : g_first
      assign left_w = val_q;
    end else begin : g_mid_l
      assign left_w = cell_data[g-1];
    end
    if (g == DEPTH - 1) begin : g_last
      assign right_w = cell_data[g];
    end else begin : g_mid_r
      assign right_w = cell_data[g+1];
    end

    bolec_cell #(
      .DW    (DW),
      .AW    (AW),
      .CW    (CW),
      .INDEX (g)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .op_i    (op),
      .at_i    (at),
      .count_i (cnt_q),
      .value_i (val_q),
      .left_i  (left_w),
      .right_i (right_w),
      .data_o  (cell_data[g]),
      .match_o (match_vec[g])
    );
  end

  // command decode and sequencing
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    ok_d    = ok_q;
    dat_d   = dat_q;
    op      = '0;
    at      = '0;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          state_d = S_MATCH;
        end
      end
      S_MATCH: begin
        op.compare = 1'b1;
        state_d    = S_EXEC;
      end
      S_EXEC: begin
        ok_d    = 1'b0;
        dat_d   = '0;
        state_d = S_DONE;
        case (cmd_q)
          CMD_PUSH_FRONT, CMD_PUSH_BACK, CMD_INSERT_AT: begin
            if (can_add) begin
              op.open = 1'b1;
              if (cmd_q == CMD_PUSH_FRONT) begin
                at = '0;
              end else if ((cmd_q == CMD_INSERT_AT) && pos_in) begin
                at = pos_x[AW-1:0];
              end else begin
                at = cnt_x[AW-1:0];
              end
              cnt_d = cnt_q + CW'(1);
              ok_d  = 1'b1;
            end
          end
          CMD_POP_FRONT: begin
            if (non_empty) begin
              op.close = 1'b1;
              at       = '0;
              dat_d    = cell_data[0];
              cnt_d    = cnt_q - CW'(1);
              ok_d     = 1'b1;
            end
          end
          CMD_POP_BACK: begin
            if (non_empty) begin
              dat_d = cell_data[last_x[AW-1:0]];
              cnt_d = cnt_q - CW'(1);
              ok_d  = 1'b1;
            end
          end
          CMD_READ_AT: begin
            if (pos_in) begin
              dat_d = cell_data[pos_x[AW-1:0]];
              ok_d  = 1'b1;
            end
          end
          CMD_REMOVE: begin
            if (found) begin
              op.close = 1'b1;
              at       = first_idx;
              dat_d    = val_q;
              cnt_d    = cnt_q - CW'(1);
              ok_d     = 1'b1;
            end
          end
          CMD_CONTAINS: begin
            if (found) begin
              dat_d = val_q;
              ok_d  = 1'b1;
            end
          end
          CMD_CLEAR: begin
            cnt_d = '0;
            ok_d  = 1'b1;
          end
          default: begin
          end
        endcase
      end
      S_DONE: begin
        if (rsp_free) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
      max_q   <= CFG_W'(64);
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      if (cfg_we_i) begin
        max_q <= cfg_wdata_i;
      end
    end
  end

  // captured item and per-item status
  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q <= bolec_cmd_e'(req_i.cmd);
      val_q <= vin;
      pos_q <= req_i.position;
    end
    ok_q  <= ok_d;
    dat_q <= dat_d;
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_valid_q <= 1'b0;
    end else if ((state_q == S_DONE) && rsp_free) begin
      rsp_valid_q <= 1'b1;
    end else if (rsp_o.ready) begin
      rsp_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if ((state_q == S_DONE) && rsp_free) begin
      rsp_ok_q    <= ok_q;
      rsp_data_q  <= to_word(dat_q);
      rsp_cnt_q   <= cnt_x[CNT_W-1:0];
      rsp_full_q  <= !can_add;
      rsp_empty_q <= !non_empty;
      rsp_front_q <= non_empty ? to_word(cell_data[0]) : '0;
      rsp_back_q  <= non_empty ? to_word(cell_data[last_x[AW-1:0]]) : '0;
    end
  end

  assign rsp_o.valid       = rsp_valid_q;
  assign rsp_o.ok          = rsp_ok_q;
  assign rsp_o.data_out    = rsp_data_q;
  assign rsp_o.entry_count = rsp_cnt_q;
  assign rsp_o.is_full     = rsp_full_q;
  assign rsp_o.is_empty    = rsp_empty_q;
  assign rsp_o.front_value = rsp_front_q;
  assign rsp_o.back_value  = rsp_back_q;

  // checks
  `BOLEC_ASSERT_NEXT(a_accept_starts_match, accept, state_q == S_MATCH, "accepted item did not start the compare step")
  `BOLEC_ASSERT_NEXT(a_count_step, (state_q == S_EXEC) && (cmd_q != CMD_CLEAR), (cnt_q == $past(cnt_q)) || (cnt_q == $past(cnt_q) + 1'b1) || (cnt_q + 1'b1 == $past(cnt_q)), "count moved by more than one")
  `BOLEC_ASSERT_IMPL(a_rsp_from_done, $rose(rsp_valid_q), $past(state_q) == S_DONE, "result raised outside the report step")

endmodule

`default_nettype wire

// ===== bench/bounded_ordered_list_engine_core_tb.sv =====
// ----------------------------------------------------------------------------
// bounded_ordered_list_engine_core_tb
// The testbench drives command items into the list engine and checks every
// result item against a model of the list that the bench keeps itself.
// It runs a directed set of edge cases, then random traffic under several
// capacity limits and handshake idling patterns, and a long output stall.
// ----------------------------------------------------------------------------
module bounded_ordered_list_engine_core_tb;
  import bolec_pkg::*;

  localparam int unsigned LIST_DEPTH = 64;
  localparam int unsigned STALL_CYCLES = 300;
  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned SETTLE_CYCLES = 8;

  // command codes outside the defined set
  localparam logic [CMD_W-1:0] CMD_UNUSED_LO = 4'h9;
  localparam logic [CMD_W-1:0] CMD_UNUSED_HI = 4'hF;

  // one result item as the engine reports it
  typedef struct packed {
    logic             ok;
    logic [VAL_W-1:0] data;
    logic [CNT_W-1:0] count;
    logic             full;
    logic             empty;
    logic [VAL_W-1:0] front;
    logic [VAL_W-1:0] back;
  } list_result_t;

  logic             clk = 1'b0;
  logic             rst_n;
  logic             cfg_we;
  logic [CFG_W-1:0] cfg_wdata;

  bolec_in_if  req_if ();
  bolec_out_if rsp_if ();

  // list model and its capacity register
  logic [VAL_W-1:0] list_words[$];
  logic [CFG_W-1:0] capacity = 7'd64;

  list_result_t pending_results[$];
  list_result_t got_result;
  list_result_t want_result;

  int unsigned mismatches = 0;
  int unsigned quiet_cycles = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  bit          stall_rsp = 1'b0;

  bounded_ordered_list_engine_core u_top (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .req_i       (req_if),
    .rsp_o       (rsp_if)
  );

  // clock
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // apply one command to the list model and return the result it gives
  function automatic list_result_t apply_command(input logic [CMD_W-1:0] op,
                                                 input logic [VAL_W-1:0] word,
                                                 input logic [POS_W-1:0] pos);
    list_result_t res;
    int unsigned  lim;
    int unsigned  at;
    res = '0;
    lim = (capacity > LIST_DEPTH) ? LIST_DEPTH : capacity;
    case (op)
      CMD_PUSH_FRONT, CMD_PUSH_BACK, CMD_INSERT_AT: begin
        if (list_words.size() < lim) begin
          if (op == CMD_PUSH_FRONT) at = 0;
          else if (op == CMD_PUSH_BACK) at = list_words.size();
          else at = (pos < list_words.size()) ? pos : list_words.size();
          if (at == list_words.size()) list_words.push_back(word);
          else list_words.insert(at, word);
          res.ok = 1'b1;
        end
      end
      CMD_POP_FRONT: begin
        if (list_words.size() != 0) begin
          res.data = list_words.pop_front();
          res.ok   = 1'b1;
        end
      end
      CMD_POP_BACK: begin
        if (list_words.size() != 0) begin
          res.data = list_words.pop_back();
          res.ok   = 1'b1;
        end
      end
      CMD_READ_AT: begin
        if (pos < list_words.size()) begin
          res.data = list_words[pos];
          res.ok   = 1'b1;
        end
      end
      CMD_REMOVE, CMD_CONTAINS: begin
        for (int i = 0; i < list_words.size(); i++) begin
          if (list_words[i] == word) begin
            res.data = list_words[i];
            res.ok   = 1'b1;
            if (op == CMD_REMOVE) list_words.delete(i);
            break;
          end
        end
      end
      CMD_CLEAR: begin
        list_words.delete();
        res.ok = 1'b1;
      end
      default: ;
    endcase
    res.count = CNT_W'(list_words.size());
    res.full  = (list_words.size() >= lim);
    res.empty = (list_words.size() == 0);
    if (list_words.size() != 0) begin
      res.front = list_words[0];
      res.back  = list_words[list_words.size() - 1];
    end
    return res;
  endfunction

  // offer one item, with a random gap first, and record its expected result
  task automatic send_item(input logic [CMD_W-1:0] op, input logic [VAL_W-1:0] word,
                           input logic [POS_W-1:0] pos);
    if ($urandom_range(0, 99) < send_idle_pct) begin
      req_if.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < send_idle_pct);
    end
    req_if.valid    <= 1'b1;
    req_if.cmd      <= op;
    req_if.value    <= word;
    req_if.position <= pos;
    do @(posedge clk); while (!req_if.ready);
    pending_results.push_back(apply_command(op, word, pos));
  endtask

  // build a random item from the current list contents
  task automatic send_random_item(input int unsigned grow_pct);
    logic [CMD_W-1:0] op;
    logic [VAL_W-1:0] word;
    logic [POS_W-1:0] pos;
    int unsigned      roll;
    roll = $urandom_range(0, 99);
    if (roll < grow_pct) begin
      case ($urandom_range(0, 2))
        0:       op = CMD_PUSH_FRONT;
        1:       op = CMD_PUSH_BACK;
        default: op = CMD_INSERT_AT;
      endcase
    end else if (roll < 99) begin
      case ($urandom_range(0, 4))
        0:       op = CMD_POP_FRONT;
        1:       op = CMD_POP_BACK;
        2:       op = CMD_READ_AT;
        3:       op = CMD_REMOVE;
        default: op = CMD_CONTAINS;
      endcase
    end else begin
      op = CMD_CLEAR;
    end
    // words already held make searches hit, small words make duplicates
    roll = $urandom_range(0, 9);
    if (roll < 4 && list_words.size() != 0)
      word = list_words[$urandom_range(0, list_words.size() - 1)];
    else if (roll < 7)
      word = $urandom_range(0, 7);
    else
      word = $urandom();
    if ($urandom_range(0, 9) < 7) pos = POS_W'($urandom_range(0, list_words.size()));
    else pos = POS_W'($urandom_range(0, LIST_DEPTH));
    send_item(op, word, pos);
  endtask

  // stop offering and wait for every outstanding result
  task automatic wait_drained();
    req_if.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // capacity write, only with the engine idle
  task automatic write_capacity(input logic [CFG_W-1:0] limit);
    wait_drained();
    cfg_we    <= 1'b1;
    cfg_wdata <= limit;
    @(posedge clk);
    capacity = limit;
    cfg_we <= 1'b0;
  endtask

  // empty list, ends of the word range, inserts, searches, full and clear
  task automatic test_directed_cases();
    send_item(CMD_POP_FRONT, '0, '0);
    send_item(CMD_POP_BACK, '0, '0);
    send_item(CMD_READ_AT, '0, '0);
    send_item(CMD_REMOVE, 32'd5, '0);
    send_item(CMD_CONTAINS, 32'd5, '0);
    send_item(CMD_PUSH_FRONT, 32'hFFFF_FFFF, '0);
    send_item(CMD_PUSH_BACK, 32'h0000_0000, '0);
    send_item(CMD_INSERT_AT, 32'h5A5A_A5A5, 7'd64);
    send_item(CMD_INSERT_AT, 32'd1, 7'd0);
    send_item(CMD_INSERT_AT, 32'd2, 7'd2);
    send_item(CMD_READ_AT, '0, 7'd4);
    send_item(CMD_READ_AT, '0, 7'd64);
    // a stored zero word is found and reported as data 0 with ok set
    send_item(CMD_CONTAINS, 32'd0, '0);
    send_item(CMD_REMOVE, 32'd0, '0);
    send_item(CMD_UNUSED_HI, 32'hFFFF_FFFF, 7'd64);
    send_item(CMD_UNUSED_LO, 32'd1, 7'd1);
    // limit lowered below the number of entries held
    write_capacity(7'd2);
    send_item(CMD_PUSH_BACK, 32'd7, '0);
    send_item(CMD_POP_BACK, '0, '0);
    send_item(CMD_POP_FRONT, '0, '0);
    send_item(CMD_POP_FRONT, '0, '0);
    send_item(CMD_PUSH_FRONT, 32'd3, '0);
    // limit of a single entry
    write_capacity(7'd1);
    send_item(CMD_INSERT_AT, 32'd9, 7'd0);
    send_item(CMD_CLEAR, '0, '0);
    send_item(CMD_PUSH_BACK, 32'h8000_0001, '0);
    send_item(CMD_CLEAR, '0, '0);
  endtask

  // random commands at one capacity limit
  task automatic test_random_traffic(input logic [CFG_W-1:0] limit, input int unsigned n,
                                     input int unsigned grow_pct);
    write_capacity(limit);
    repeat (n) send_random_item(grow_pct);
  endtask

  // hold the result side off while items keep coming, so the input stalls
  task automatic test_output_backpressure();
    wait_drained();
    stall_rsp = 1'b1;
    repeat (30) send_random_item(60);
    wait_drained();
  endtask

  // result side ready, with random idling and the long hold-off
  initial begin
    rsp_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (stall_rsp) begin
        rsp_if.ready <= 1'b0;
        repeat (STALL_CYCLES) @(posedge clk);
        stall_rsp = 1'b0;
      end
      rsp_if.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // compare one field and report the first few mismatches
  task automatic check_field(input string name, input logic [VAL_W-1:0] want,
                             input logic [VAL_W-1:0] got);
    if (want !== got) begin
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch on %s: expected %h, got %h", name, want, got);
    end
  endtask

  // result checker
  always @(posedge clk) begin
    if (rst_n && rsp_if.valid && rsp_if.ready) begin
      got_result.ok    = rsp_if.ok;
      got_result.data  = rsp_if.data_out;
      got_result.count = rsp_if.entry_count;
      got_result.full  = rsp_if.is_full;
      got_result.empty = rsp_if.is_empty;
      got_result.front = rsp_if.front_value;
      got_result.back  = rsp_if.back_value;
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("result item with none expected: %p", got_result);
      end else begin
        want_result = pending_results.pop_front();
        check_field("ok", VAL_W'(want_result.ok), VAL_W'(got_result.ok));
        check_field("data_out", want_result.data, got_result.data);
        check_field("entry_count", VAL_W'(want_result.count), VAL_W'(got_result.count));
        check_field("is_full", VAL_W'(want_result.full), VAL_W'(got_result.full));
        check_field("is_empty", VAL_W'(want_result.empty), VAL_W'(got_result.empty));
        check_field("front_value", want_result.front, got_result.front);
        check_field("back_value", want_result.back, got_result.back);
      end
    end
  end

  // watchdog on cycles with no item moving on either side
  always @(posedge clk) begin
    if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no item moved for %0d cycles", quiet_cycles);
      $display("Regression FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // test sequence
  initial begin
    rst_n           <= 1'b0;
    cfg_we          <= 1'b0;
    cfg_wdata       <= '0;
    req_if.valid    <= 1'b0;
    req_if.cmd      <= CMD_PUSH_FRONT;
    req_if.value    <= '0;
    req_if.position <= '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // sender idles lightly, receiver heavily
    send_idle_pct = 25;
    recv_idle_pct = 77;
    test_directed_cases();
    test_random_traffic(7'd64, 130, 60);
    test_random_traffic(7'd5, 60, 50);

    // the other way round, filling the whole list
    send_idle_pct = 77;
    recv_idle_pct = 25;
    test_random_traffic(7'd64, 130, 72);
    test_random_traffic(7'd1, 40, 50);

    // no idling
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_traffic(7'd12, 120, 55);
    test_output_backpressure();

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
